@@ hdl/hcs_pkg.sv @@
// Hamiltonian cycle search: shared types and constants.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package hcs_pkg;

   // Width of the adjacency beat and of the vertex / position result fields
   localparam int ADJ_W   = 25;
   localparam int FIELD_W = 3;

   typedef logic [FIELD_W-1:0] field_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;   // take the adjacency beat and seed the path with vertex 0
      logic step;   // run one search step
      logic emit;   // load the next result beat into the output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic found_done;  // this step closed a cycle
      logic fail_done;   // this step backtracked past the start
      logic out_free;    // output register can take a beat this cycle
      logic emit_last;   // the beat offered now is the final one of the item
   } status_type;

endpackage

@@ hdl/hcs_req_if.sv @@
// Request channel: one adjacency matrix per beat, valid/ready handshake.
// Depends on hcs_pkg.
interface hcs_req_if;
   logic                        valid;
   logic                        ready;
   logic [hcs_pkg::ADJ_W-1:0]   adjacency_bits;

   modport source (output valid, output adjacency_bits, input ready);
   modport sink   (input valid, input adjacency_bits, output ready);
endinterface

@@ hdl/hcs_rsp_if.sv @@
// Response channel: one result per beat, valid/ready handshake.
// Depends on hcs_pkg.
interface hcs_rsp_if;
   logic                  valid;
   logic                  ready;
   logic                  found;
   hcs_pkg::field_type    vertex_index;
   hcs_pkg::field_type    visit_position;
   logic                  last_result;

   modport source (output valid, output found, output vertex_index,
                   output visit_position, output last_result, input ready);
   modport sink   (input valid, input found, input vertex_index,
                   input visit_position, input last_result, output ready);
endinterface

@@ hdl/hamiltonian_cycle_search.sv @@
// Hamiltonian cycle search. Each request beat carries a directed adjacency
// matrix (bit row*VERTEX_COUNT+col marks the edge row -> col; bits past the
// beat width read as no edge). The block walks a depth-first search from
// vertex 0, trying the lowest-numbered free neighbour first and backtracking
// when a level runs out of candidates, until it closes a cycle back to vertex
// 0 or exhausts the search. A found cycle gives VERTEX_COUNT response beats,
// one per vertex in vertex order, with the vertex's position on the cycle;
// no cycle gives one beat with found low. last_result marks the final beat.
// After the request is taken the search runs step by step, where a step tests
// a single candidate vertex, checks the closing edge or backtracks one level.
// Response beats follow at one per cycle when the sink is ready. One item is
// in flight at a time: the next request is taken in the cycle after the final
// response beat enters the output register.
// Depends on hcs_pkg, hcs_req_if, hcs_rsp_if, hcs_ctrl and hcs_datapath.
module hamiltonian_cycle_search #(
   parameter int VERTEX_COUNT = 5
) (
   input  logic       clock,
   input  logic       reset,
   hcs_req_if.sink    req_bus,
   hcs_rsp_if.source  rsp_bus
);

   hcs_pkg::cmd_type    cmd;
   hcs_pkg::status_type status;
   logic                req_ready;

   // Sequencer
   hcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_bus.ready = req_ready;

   // Search state and result register
   hcs_datapath #(
      .VERTEX_COUNT (VERTEX_COUNT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .adjacency_bits (req_bus.adjacency_bits),
      .cmd            (cmd),
      .status         (status),
      .rsp_bus        (rsp_bus)
   );

endmodule

@@ hdl/hcs_ctrl.sv @@
// Hamiltonian cycle search: sequencing state machine.
// Depends on hcs_pkg; drives commands into hcs_datapath and reads its status.
module hcs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  hcs_pkg::status_type status,
   output hcs_pkg::cmd_type    cmd
);

   hcs_pkg::state_type state_ff;
   hcs_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hcs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         hcs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            if (req_valid) begin
               state_in = hcs_pkg::ST_SEARCH;
            end
         end
         hcs_pkg::ST_SEARCH: begin
            cmd.step = 1'b1;
            if (status.found_done || status.fail_done) begin
               state_in = hcs_pkg::ST_EMIT;
            end
         end
         hcs_pkg::ST_EMIT: begin
            cmd.emit = status.out_free;
            if (status.out_free && status.emit_last) begin
               state_in = hcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hcs_pkg::ST_IDLE;
         end
      endcase
   end

   // An accepted beat always starts a search
   a_load_to_search: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == hcs_pkg::ST_SEARCH))
      else $error("accepted beat did not start a search");

   // Final beat handed over returns the block to idle
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.emit_last) |=> (state_ff == hcs_pkg::ST_IDLE))
      else $error("block not idle after the final result beat");

   // A step cannot both close a cycle and exhaust the search
   a_single_outcome: assert property (@(posedge clock) disable iff (reset)
      !(status.found_done && status.fail_done))
      else $error("search reported found and not found together");

endmodule

@@ hdl/hcs_datapath.sv @@
// Hamiltonian cycle search: path stacks, visited set and output register.
// Depends on hcs_pkg and hcs_rsp_if; commanded by hcs_ctrl.
module hcs_datapath #(
   parameter int VERTEX_COUNT = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [hcs_pkg::ADJ_W-1:0]   adjacency_bits,
   input  hcs_pkg::cmd_type            cmd,
   output hcs_pkg::status_type         status,
   hcs_rsp_if.source                   rsp_bus
);

   localparam int IDX_W = $clog2(VERTEX_COUNT);
   localparam int CNT_W = $clog2(VERTEX_COUNT + 1);

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   // Adjacency rows: adj_ff[row][col] is the edge row -> col
   logic [VERTEX_COUNT-1:0] adj_mat [VERTEX_COUNT];
   logic [VERTEX_COUNT-1:0] adj_ff  [VERTEX_COUNT];

   logic [VERTEX_COUNT-1:0] visited_ff, visited_in;
   idx_type                 pos_ff  [VERTEX_COUNT];
   idx_type                 pos_in  [VERTEX_COUNT];
   cnt_type                 cand_ff [VERTEX_COUNT];
   cnt_type                 cand_in [VERTEX_COUNT];
   idx_type                 path_ff [VERTEX_COUNT];
   idx_type                 path_in [VERTEX_COUNT];
   cnt_type                 depth_ff, depth_in;
   logic                    found_ff, found_in;
   idx_type                 emit_ff, emit_in;

   logic                    rsp_valid_ff;
   logic                    rsp_found_ff;
   hcs_pkg::field_type      rsp_vertex_ff;
   hcs_pkg::field_type      rsp_position_ff;
   logic                    rsp_last_ff;

   idx_type                 d_idx, dm1_idx, cur_idx, from_v;
   cnt_type                 dm1, dp1, cur;
   logic                    at_end, closes, exhausted, fit, backtrack, beat_last;

   // Unpack the beat into rows; bits beyond the beat width read as no edge
   for (genvar r = 0; r < VERTEX_COUNT; r++) begin : g_row
      for (genvar c = 0; c < VERTEX_COUNT; c++) begin : g_col
         localparam int BIT = r * VERTEX_COUNT + c;
         if (BIT < hcs_pkg::ADJ_W) begin : g_in
            assign adj_mat[r][c] = adjacency_bits[BIT];
         end else begin : g_out
            assign adj_mat[r][c] = 1'b0;
         end
      end
   end

   // Decode the current search step
   always_comb begin
      d_idx     = depth_ff[IDX_W-1:0];
      dm1       = depth_ff - cnt_type'(1);
      dp1       = depth_ff + cnt_type'(1);
      dm1_idx   = dm1[IDX_W-1:0];
      at_end    = (depth_ff == cnt_type'(VERTEX_COUNT));
      cur       = cand_ff[d_idx];
      cur_idx   = cur[IDX_W-1:0];
      exhausted = (cur == cnt_type'(VERTEX_COUNT));
      from_v    = path_ff[dm1_idx];
      closes    = adj_ff[path_ff[VERTEX_COUNT-1]][0];
      fit       = adj_ff[from_v][cur_idx] && !visited_ff[cur_idx];
      backtrack = at_end ? !closes : exhausted;
   end

   // Next path state
   always_comb begin
      visited_in = visited_ff;
      pos_in     = pos_ff;
      cand_in    = cand_ff;
      path_in    = path_ff;
      depth_in   = depth_ff;
      found_in   = found_ff;
      emit_in    = emit_ff;
      if (cmd.load) begin
         // Seed the path with vertex 0 at position 0
         visited_in = VERTEX_COUNT'(1);
         pos_in[0]  = '0;
         path_in[0] = '0;
         for (int i = 0; i < VERTEX_COUNT; i++) begin
            cand_in[i] = '0;
         end
         depth_in = cnt_type'(1);
      end else if (cmd.step) begin
         if (at_end && closes) begin
            found_in = 1'b1;
            emit_in  = '0;
         end else if (backtrack) begin
            if (depth_ff <= cnt_type'(1)) begin
               found_in = 1'b0;
               emit_in  = '0;
            end else begin
               // Drop the most recently placed vertex
               depth_in                    = dm1;
               visited_in[path_ff[dm1_idx]] = 1'b0;
            end
         end else if (fit) begin
            // Place the candidate and open the next level
            path_in[d_idx]      = cur_idx;
            pos_in[cur_idx]     = d_idx;
            visited_in[cur_idx] = 1'b1;
            cand_in[d_idx]      = cur + cnt_type'(1);
            depth_in            = dp1;
            if (dp1 < cnt_type'(VERTEX_COUNT)) begin
               cand_in[dp1[IDX_W-1:0]] = '0;
            end
         end else begin
            // Advance to the next candidate at this level
            cand_in[d_idx] = cur + cnt_type'(1);
         end
      end else if (cmd.emit) begin
         emit_in = emit_ff + idx_type'(1);
      end
   end

   // Search state registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         adj_ff <= adj_mat;
      end
      visited_ff <= visited_in;
      pos_ff     <= pos_in;
      cand_ff    <= cand_in;
      path_ff    <= path_in;
      depth_ff   <= depth_in;
      found_ff   <= found_in;
      emit_ff    <= emit_in;
   end

   assign beat_last = !found_ff || (emit_ff == idx_type'(VERTEX_COUNT - 1));

   // Output register: hold a beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_found_ff    <= found_ff;
         rsp_vertex_ff   <= found_ff ? hcs_pkg::field_type'(emit_ff) : '0;
         rsp_position_ff <= found_ff ? hcs_pkg::field_type'(pos_ff[emit_ff]) : '0;
         rsp_last_ff     <= beat_last;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.found          = rsp_found_ff;
   assign rsp_bus.vertex_index   = rsp_vertex_ff;
   assign rsp_bus.visit_position = rsp_position_ff;
   assign rsp_bus.last_result    = rsp_last_ff;

   // Status back to the controller
   always_comb begin
      status            = '0;
      status.found_done = cmd.step && at_end && closes;
      status.fail_done  = cmd.step && backtrack && (depth_ff <= cnt_type'(1));
      status.out_free   = !rsp_valid_ff || rsp_bus.ready;
      status.emit_last  = beat_last;
   end

   // The visited set always matches the path depth while searching
   a_visited_depth: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> ($countones(visited_ff) == int'(depth_ff)))
      else $error("visited set out of step with path depth");

   // A full path has every vertex visited
   a_full_path: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && at_end) |-> (&visited_ff))
      else $error("full-depth path with an unvisited vertex");

   // Never overwrite a beat that has not been taken
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_bus.ready))
      else $error("result beat overwritten before it was taken");

endmodule

@@ dv/hamiltonian_cycle_search_test.sv @@
`timescale 1ns / 100ps
// Testbench for hamiltonian_cycle_search: drives adjacency beats, predicts the cycle search
// in a local depth-first model and checks every response beat in order.
// Depends on hcs_pkg, hcs_req_if, hcs_rsp_if and the hamiltonian_cycle_search RTL.
module hamiltonian_cycle_search_test;

   localparam int         VERTICES    = 5;
   localparam logic [3:0] UNVISITED   = 4'd15;
   localparam int         RANDOM_BEATS = 256;
   localparam int         LONG_HOLD   = 400;
   localparam int         DRAIN_CYCLES = 400;

   typedef logic [hcs_pkg::ADJ_W-1:0] adj_type;

   typedef struct packed {
      logic               found;
      hcs_pkg::field_type vertex_index;
      hcs_pkg::field_type visit_position;
      logic               last_result;
   } cycle_beat_type;

   logic clock;
   logic reset;

   hcs_req_if req_bus ();
   hcs_rsp_if rsp_bus ();

   hamiltonian_cycle_search #(
      .VERTEX_COUNT (VERTICES)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   cycle_beat_type expected_beats[$];
   int             mismatch_count = 0;
   bit             sender_idles = 1'b1;
   bit             sink_idles = 1'b1;
   int             long_hold_cycles = 0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit, far above the slowest legal run
   initial begin
      #(20_000_000);
      $display("hamiltonian_cycle_search_test: done, errors");
      $finish;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap(input bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic adj_type edge_mask(input int from, input int to);
      adj_type m;
      m = '0;
      m[from * VERTICES + to] = 1'b1;
      return m;
   endfunction

   // Directed cycle 0 -> a -> b -> c -> d -> 0
   function automatic adj_type ring(input int a, input int b, input int c, input int d);
      return edge_mask(0, a) | edge_mask(a, b) | edge_mask(b, c) | edge_mask(c, d)
             | edge_mask(d, 0);
   endfunction

   // Depth-first search from vertex 0, lowest free neighbour first; queue the beats it gives
   function automatic void predict_cycle(input adj_type adj);
      logic [3:0]     place_of [VERTICES];
      logic [3:0]     next_try [VERTICES];
      logic [2:0]     route [VERTICES];
      int             level;
      int             c;
      bit             advanced;
      bit             closed;
      bit             done;
      cycle_beat_type beat;

      for (int i = 0; i < VERTICES; i++) begin
         place_of[i] = UNVISITED;
         next_try[i] = '0;
         route[i]    = '0;
      end
      place_of[0] = '0;
      level  = 1;
      closed = 1'b0;
      done   = 1'b0;

      while (!done) begin
         advanced = 1'b0;
         if (level >= VERTICES) begin
            // all placed: succeed only on an edge back to vertex 0
            if (adj[int'(route[VERTICES-1]) * VERTICES]) begin
               closed = 1'b1;
               done   = 1'b1;
            end
         end else begin
            for (c = int'(next_try[level]); c < VERTICES && !advanced; c++) begin
               if (adj[int'(route[level-1]) * VERTICES + c] && place_of[c] == UNVISITED) begin
                  route[level]    = c[2:0];
                  place_of[c]     = level[3:0];
                  next_try[level] = 4'(c + 1);
                  level++;
                  if (level < VERTICES) next_try[level] = '0;
                  advanced = 1'b1;
               end
            end
            if (!advanced) next_try[level] = 4'(VERTICES);
         end
         // backtrack one level, or give up at the start vertex
         if (!done && !advanced) begin
            if (level <= 1) begin
               done = 1'b1;
            end else begin
               level--;
               place_of[route[level]] = UNVISITED;
            end
         end
      end

      if (closed) begin
         for (int v = 0; v < VERTICES; v++) begin
            beat.found          = 1'b1;
            beat.vertex_index   = hcs_pkg::field_type'(v);
            beat.visit_position = place_of[v][2:0];
            beat.last_result    = (v == VERTICES - 1);
            expected_beats.push_back(beat);
         end
      end else begin
         beat = '{found: 1'b0, vertex_index: '0, visit_position: '0, last_result: 1'b1};
         expected_beats.push_back(beat);
      end
   endfunction

   // Offer one adjacency beat; hold valid until accepted, then queue its predicted results
   task automatic send_adjacency(input adj_type adj);
      int gap;
      gap = pick_gap(sender_idles);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.adjacency_bits <= adj;
      do @(posedge clock); while (!req_bus.ready);
      predict_cycle(adj);
   endtask

   // Sink: random stalls, or one long hold when a test asks for it
   initial begin : sink_driver
      int gap;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_cycles > 0) begin
            gap = long_hold_cycles;
            long_hold_cycles = 0;
         end else begin
            gap = pick_gap(sink_idles);
         end
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   // Compare each accepted response beat with the oldest prediction
   always @(posedge clock) begin
      cycle_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected response beat: found %0d vertex %0d position %0d last %0d",
                   rsp_bus.found, rsp_bus.vertex_index, rsp_bus.visit_position,
                   rsp_bus.last_result);
            mismatch_count++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp_bus.found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_bus.found);
               mismatch_count++;
            end
            if (rsp_bus.vertex_index !== want.vertex_index) begin
               $error("vertex_index: expected %0d, got %0d", want.vertex_index,
                      rsp_bus.vertex_index);
               mismatch_count++;
            end
            if (rsp_bus.visit_position !== want.visit_position) begin
               $error("visit_position: expected %0d, got %0d", want.visit_position,
                      rsp_bus.visit_position);
               mismatch_count++;
            end
            if (rsp_bus.last_result !== want.last_result) begin
               $error("last_result: expected %0d, got %0d", want.last_result,
                      rsp_bus.last_result);
               mismatch_count++;
            end
         end
      end
   end

   // Extremes, both cycle directions, self loops, dead ends and forced backtracking
   task automatic test_directed_graphs();
      adj_type all_ones;
      adj_type self_loops;
      adj_type into_zero;
      adj_type out_of_zero;
      adj_type out_of_three;
      all_ones     = '1;
      self_loops   = '0;
      into_zero    = '0;
      out_of_zero  = '0;
      out_of_three = '0;
      for (int v = 0; v < VERTICES; v++) begin
         self_loops   |= edge_mask(v, v);
         into_zero    |= edge_mask(v, 0);
         out_of_zero  |= edge_mask(0, v);
         out_of_three |= edge_mask(3, v);
      end
      send_adjacency('0);
      send_adjacency(all_ones);
      send_adjacency(edge_mask(0, 0));
      send_adjacency(edge_mask(4, 4));
      send_adjacency(ring(1, 2, 3, 4));
      send_adjacency(ring(4, 3, 2, 1));
      // open path only, closing edge missing
      send_adjacency(ring(1, 2, 3, 4) & ~edge_mask(4, 0));
      send_adjacency(ring(2, 4, 1, 3) | self_loops);
      send_adjacency(self_loops);
      send_adjacency(ring(2, 4, 1, 3) | ring(3, 1, 4, 2));
      // decoy branches from vertex 0 force the search to back up
      send_adjacency(ring(4, 2, 3, 1) | edge_mask(0, 1) | edge_mask(0, 2) | edge_mask(1, 3)
                     | edge_mask(2, 1));
      send_adjacency(all_ones & ~into_zero);
      send_adjacency(all_ones & ~out_of_zero);
      send_adjacency(all_ones & ~out_of_three);
      send_adjacency(all_ones & ~self_loops);
      // Hamiltonian path whose end leads back to vertex 1 only
      send_adjacency((ring(1, 2, 3, 4) & ~edge_mask(4, 0)) | edge_mask(4, 1));
      // two disjoint cycles
      send_adjacency(edge_mask(0, 1) | edge_mask(1, 0) | edge_mask(2, 3) | edge_mask(3, 4)
                     | edge_mask(4, 2));
      send_adjacency(all_ones & ~edge_mask(0, 1) & ~edge_mask(1, 2));
   endtask

   // Mostly graphs with a planted cycle and random extra edges, the rest noise or broken rings
   function automatic adj_type random_graph();
      int      order [4];
      int      j;
      int      t;
      int      r;
      adj_type planted;
      for (int i = 0; i < 4; i++) order[i] = i + 1;
      for (int i = 3; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      planted = ring(order[0], order[1], order[2], order[3]);
      r = $urandom_range(0, 99);
      if (r < 45) return planted | adj_type'($urandom & $urandom & $urandom);
      if (r < 65) return planted | adj_type'($urandom);
      if (r < 75) begin
         // broken ring: drop one of its edges
         j = $urandom_range(0, 3);
         return (planted & ~edge_mask(order[j], (j == 3) ? 0 : order[j+1]))
                | adj_type'($urandom & $urandom & $urandom);
      end
      if (r < 90) return adj_type'($urandom & $urandom);
      return adj_type'($urandom);
   endfunction

   // Random graphs: idling on both sides, then a stretch with none, then idling again
   task automatic test_random_graphs();
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         sender_idles = !(n >= 100 && n < 150);
         sink_idles   = !(n >= 100 && n < 150);
         send_adjacency(random_graph());
      end
   endtask

   // Hold the sink off for a long stretch while beats keep coming, so the block backs up
   task automatic test_stalled_sink();
      long_hold_cycles = LONG_HOLD;
      sender_idles = 1'b0;
      for (int n = 0; n < 6; n++) send_adjacency(random_graph());
      sender_idles = 1'b1;
   endtask

   initial begin
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.adjacency_bits = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed_graphs();
      test_stalled_sink();
      test_random_graphs();
      req_bus.valid <= 1'b0;

      // drain, then watch for stray beats
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_beats.size() != 0) begin
         $error("%0d expected response beats never arrived", expected_beats.size());
         mismatch_count++;
      end

      if (mismatch_count == 0) begin
         $display("hamiltonian_cycle_search_test: done, clean");
      end else begin
         $display("hamiltonian_cycle_search_test: done, errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/hcs_pkg.sv
hdl/hcs_req_if.sv
hdl/hcs_rsp_if.sv
hdl/hcs_ctrl.sv
hdl/hcs_datapath.sv
hdl/hamiltonian_cycle_search.sv
dv/hamiltonian_cycle_search_test.sv
